// File: src/b64lw_pkg.sv
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, constants and the Base64 alphabet for the line-wrapping
// Base64 encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

    // Widths of the channel fields and configuration registers.
    localparam int BYTE_W      = 8;
    localparam int LIMIT_W     = 10;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 2;

    // Largest number of characters one input transfer can cause.
    localparam int NUM_SLOTS   = 8;
    localparam int SLOT_CNT_W  = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LIMIT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BREAK_FIRST  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BREAK_SECOND = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BREAK_IS_TWO = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_W-1:0] LINE_LIMIT_RST   = 10'd76;
    localparam logic [BYTE_W-1:0]  BREAK_FIRST_RST  = 8'd13;
    localparam logic [BYTE_W-1:0]  BREAK_SECOND_RST = 8'd10;

    // Characters.
    localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;

    // Group positions (number of bytes held back).
    localparam logic [1:0] GP_EMPTY = 2'd0;
    localparam logic [1:0] GP_ONE   = 2'd1;
    localparam logic [1:0] GP_TWO   = 2'd2;

    // Configuration register set.
    typedef struct packed {
        logic [LIMIT_W-1:0] line_limit;
        logic [BYTE_W-1:0]  break_first;
        logic [BYTE_W-1:0]  break_second;
        logic               break_is_two;
    } cfg_t;

    // Characters caused by one input transfer, handed to the serializer.
    typedef struct packed {
        logic [NUM_SLOTS-1:0][BYTE_W-1:0] chars;
        logic [SLOT_CNT_W-1:0]            count;
        logic                             fin;
    } job_t;

    // Map a 6-bit value onto the standard Base64 alphabet.
    function automatic logic [BYTE_W-1:0] b64_char(input logic [5:0] v);
        logic [BYTE_W-1:0] c;
        c = 8'h2F;
        if (v < 6'd26)
            c = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'h61 + {2'b00, v - 6'd26};
        else if (v < 6'd62)
            c = 8'h30 + {2'b00, v - 6'd52};
        else if (v == 6'd62)
            c = 8'h2B;
        return c;
    endfunction

endpackage

// File: src/b64lw_if.sv
// ----------------------------------------------------------------------------
// b64lw_in_if / b64lw_out_if
// Valid/ready channels for message bytes in and encoded characters out.
// ----------------------------------------------------------------------------
interface b64lw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       message_end;

    modport source (output valid, output data_byte, output has_byte,
                    output message_end, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input message_end, output ready);
endinterface

interface b64lw_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;
    logic       message_done;

    modport source (output valid, output out_char, output run_last,
                    output message_done, input ready);
    modport sink   (input valid, input out_char, input run_last,
                    input message_done, output ready);
endinterface

// File: src/b64lw_encode.sv
// ----------------------------------------------------------------------------
// b64lw_encode
// Holds the pending bytes, group position and line count, and turns each
// accepted input transfer into a registered list of up to eight characters.
// ----------------------------------------------------------------------------
module b64lw_encode
    import b64lw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_has,
    input  logic              in_fin,
    output logic              job_valid,
    output job_t              job,
    input  logic              job_take
);

    logic [2*BYTE_W-1:0] pend_reg, pend_next;
    logic [1:0]          gp_reg, gp_next;
    logic [LIMIT_W-1:0]  cnt_reg, cnt_next;
    logic                job_valid_reg, job_valid_next;
    job_t                job_reg, job_next;

    logic                accept;
    logic                do_group;
    logic                wrap;
    logic [LIMIT_W-1:0]  thr;
    logic [LIMIT_W-1:0]  cnt_plus;
    logic [BYTE_W-1:0]   p1, p2;
    logic [1:0]          eff_gp;

    // The job register is free when empty or when it moves on this cycle.
    assign in_ready  = !job_valid_reg || job_take;
    assign accept    = in_valid && in_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    // Line count after a group and the wrap decision.
    assign thr      = (cfg.line_limit >= 10'd3) ? cfg.line_limit - 10'd3 : '0;
    assign cnt_plus = cnt_reg + 10'd4;
    assign do_group = in_has && (gp_reg != GP_EMPTY) && (gp_reg != GP_ONE);
    assign wrap     = cnt_plus >= thr;

    // Pending bytes as seen by the end-of-message flush.
    always_comb
    begin
        p1     = pend_reg[15:8];
        p2     = pend_reg[7:0];
        eff_gp = gp_reg;
        if (in_has)
        begin
            case (gp_reg)
                GP_EMPTY:
                begin
                    p1     = in_byte;
                    eff_gp = GP_ONE;
                end
                GP_ONE:
                begin
                    p2     = in_byte;
                    eff_gp = GP_TWO;
                end
                default:
                begin
                    eff_gp = GP_EMPTY;
                end
            endcase
        end
    end

    // Build the character list for this transfer.
    always_comb
    begin
        logic [SLOT_CNT_W-1:0] n;
        n              = '0;
        job_next.chars = '0;
        job_next.fin   = in_fin;
        if (do_group)
        begin
            job_next.chars[0] = b64_char(pend_reg[15:10]);
            job_next.chars[1] = b64_char({pend_reg[9:8], pend_reg[7:4]});
            job_next.chars[2] = b64_char({pend_reg[3:0], in_byte[7:6]});
            job_next.chars[3] = b64_char(in_byte[5:0]);
            n = 4'd4;
            if (wrap)
            begin
                job_next.chars[n[2:0]] = cfg.break_first;
                n = n + 4'd1;
                if (cfg.break_is_two)
                begin
                    job_next.chars[n[2:0]] = cfg.break_second;
                    n = n + 4'd1;
                end
            end
        end
        if (in_fin)
        begin
            // A padded group is only possible when no full group went out.
            if (eff_gp == GP_ONE)
            begin
                job_next.chars[0] = b64_char(p1[7:2]);
                job_next.chars[1] = b64_char({p1[1:0], 4'b0000});
                job_next.chars[2] = PAD_CHAR;
                job_next.chars[3] = PAD_CHAR;
                n = 4'd4;
            end
            else if (eff_gp == GP_TWO)
            begin
                job_next.chars[0] = b64_char(p1[7:2]);
                job_next.chars[1] = b64_char({p1[1:0], p2[7:4]});
                job_next.chars[2] = b64_char({p2[3:0], 2'b00});
                job_next.chars[3] = PAD_CHAR;
                n = 4'd4;
            end
            job_next.chars[n[2:0]] = cfg.break_first;
            n = n + 4'd1;
            if (cfg.break_is_two)
            begin
                job_next.chars[n[2:0]] = cfg.break_second;
                n = n + 4'd1;
            end
        end
        job_next.count = n;
    end

    // Next state of the encoder.
    always_comb
    begin
        pend_next      = pend_reg;
        gp_next        = gp_reg;
        cnt_next       = cnt_reg;
        job_valid_next = job_valid_reg && !job_take;
        if (accept)
        begin
            job_valid_next = (job_next.count != '0);
            if (in_has)
            begin
                case (gp_reg)
                    GP_EMPTY:
                    begin
                        pend_next = {in_byte, 8'h00};
                        gp_next   = GP_ONE;
                    end
                    GP_ONE:
                    begin
                        pend_next = {pend_reg[15:8], in_byte};
                        gp_next   = GP_TWO;
                    end
                    default:
                    begin
                        pend_next = '0;
                        gp_next   = GP_EMPTY;
                        cnt_next  = wrap ? '0 : cnt_plus;
                    end
                endcase
            end
            if (in_fin)
            begin
                pend_next = '0;
                gp_next   = GP_EMPTY;
                cnt_next  = '0;
            end
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            gp_reg        <= GP_EMPTY;
            cnt_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            gp_reg        <= gp_next;
            cnt_reg       <= cnt_next;
            job_valid_reg <= job_valid_next;
        end
    end

    // Job payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// File: src/b64lw_serial.sv
// ----------------------------------------------------------------------------
// b64lw_serial
// Shifts a character list out one character per output transfer and marks
// the last character of each list and of each message.
// ----------------------------------------------------------------------------
module b64lw_serial
    import b64lw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  job_t              job,
    output logic              job_take,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_char,
    output logic              run_last,
    output logic              message_done
);

    logic [NUM_SLOTS-1:0][BYTE_W-1:0] chars_reg, chars_next;
    logic [SLOT_CNT_W-1:0]            left_reg, left_next;
    logic                             fin_reg, fin_next;
    logic                             xfer;
    logic                             last;

    assign out_valid    = (left_reg != '0);
    assign last         = (left_reg == 4'd1);
    assign xfer         = out_valid && out_ready;
    assign out_char     = chars_reg[0];
    assign run_last     = last;
    assign message_done = last && fin_reg;

    // Take a new list when empty or when the last character leaves now.
    assign job_take = job_valid && (!out_valid || (xfer && last));

    // Shift on each transfer, reload from the job register.
    always_comb
    begin
        chars_next = chars_reg;
        left_next  = left_reg;
        fin_next   = fin_reg;
        if (xfer)
        begin
            chars_next = {{BYTE_W{1'b0}}, chars_reg[NUM_SLOTS-1:1]};
            left_next  = left_reg - 4'd1;
        end
        if (job_take)
        begin
            chars_next = job.chars;
            left_next  = job.count;
            fin_next   = job.fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chars_reg <= chars_next;
        fin_reg   <= fin_next;
    end

endmodule

// File: src/base64_line_wrapping_encoder.sv
// ----------------------------------------------------------------------------
// base64_line_wrapping_encoder
// Base64 encoder with configurable line wrapping and line break sequence.
// ----------------------------------------------------------------------------
// Usage:
//   Message bytes enter on in_ch, one per transfer (has_byte marks a real
//   byte, message_end closes the message). Encoded characters leave on
//   out_ch, one per transfer; run_last marks the last character caused by
//   an input transfer and message_done the final line break character.
//   Every third byte releases four characters, plus a line break when the
//   line fills; message_end flushes held bytes as a padded group, then
//   a line break. With the output side idle, the first character of a
//   transfer passes through the job register and then the shift register
//   before it is on out_ch. The output side moves one character per cycle
//   while the receiver is ready; an input transfer causes up to 8
//   characters, and one that causes none leaves nothing for the output
//   side. One list of characters waits in a job register while the
//   previous one shifts out, so input is taken while output is still
//   busy. When the receiver stalls, the character on out_ch holds and
//   in_ch.ready drops once the job register is full. Reset clears the
//   group state, empties both stages and loads the configuration defaults
//   (limit 76, CR LF break). The user writes configuration through
//   cfg_we/cfg_index/cfg_data only while the block is idle; the block
//   itself does not enforce this.
// ----------------------------------------------------------------------------
module base64_line_wrapping_encoder
    import b64lw_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    b64lw_in_if.sink               in_ch,
    b64lw_out_if.source            out_ch,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic job_valid;
    job_t job;
    logic job_take;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LINE_LIMIT:   cfg_next.line_limit   = cfg_data[LIMIT_W-1:0];
                CFG_BREAK_FIRST:  cfg_next.break_first  = cfg_data[BYTE_W-1:0];
                CFG_BREAK_SECOND: cfg_next.break_second = cfg_data[BYTE_W-1:0];
                CFG_BREAK_IS_TWO: cfg_next.break_is_two = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_limit   <= LINE_LIMIT_RST;
            cfg_reg.break_first  <= BREAK_FIRST_RST;
            cfg_reg.break_second <= BREAK_SECOND_RST;
            cfg_reg.break_is_two <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Group state and character list builder.
    b64lw_encode u_encode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_byte   (in_ch.data_byte),
        .in_has    (in_ch.has_byte),
        .in_fin    (in_ch.message_end),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    // One character per output transfer.
    b64lw_serial u_serial
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .job_take     (job_take),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_char     (out_ch.out_char),
        .run_last     (out_ch.run_last),
        .message_done (out_ch.message_done)
    );

endmodule

// File: src/b64lw_checker.sv
// ----------------------------------------------------------------------------
// b64lw_checker
// Port-level checks on the Base64 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64lw_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       run_last,
    input logic       message_done
);

    // The end of a message is always the end of a transfer's characters.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_done |-> run_last)
        else $error("message_done without run_last");

    // An offered byte is only held off while characters wait on the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid)
        else $error("input stalled with an idle output");

    // A stalled character holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char)
                                    && $stable(run_last))
        else $error("output changed while stalled");

    // Nothing comes out in the cycle right after reset is released.
    a_reset_quiet: assert property (@(posedge clk)
        !$past(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind base64_line_wrapping_encoder b64lw_checker u_b64lw_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_char     (out_ch.out_char),
    .run_last     (out_ch.run_last),
    .message_done (out_ch.message_done)
);

// File: tb/sv/base64_line_wrapping_encoder_test.sv
// ----------------------------------------------------------------------------
// base64_line_wrapping_encoder_test
// Self-checking testbench for the line-wrapping Base64 encoder. A driver
// sends message bytes in random bursts and a monitor checks every encoded
// character against an in-bench encoder model, across several line lengths
// and line break sequences, with receiver stalls and a long receiver hold.
// ----------------------------------------------------------------------------
module base64_line_wrapping_encoder_test;
    import b64lw_pkg::*;

    // One message item as queued for the driver.
    typedef struct {
        logic [7:0] data;
        logic       has;
        logic       fin;
        bit         drain;
    } msg_item_t;

    // One encoded character as the block should deliver it.
    typedef struct {
        logic [7:0] ch;
        logic       run_last;
        logic       done;
    } enc_char_t;

    // How the receiver applies backpressure.
    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

    localparam int IDLE_LIMIT   = 3000;
    localparam int SETTLE_TIME  = 16;
    localparam int HOLD_CYCLES  = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Values driven onto the block's inputs.
    logic                   drv_valid     = 1'b0;
    logic [7:0]             drv_data      = 8'h00;
    logic                   drv_has       = 1'b0;
    logic                   drv_fin       = 1'b0;
    logic                   drv_ready     = 1'b0;
    logic                   drv_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] drv_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  drv_cfg_data  = '0;

    b64lw_in_if  in_ch();
    b64lw_out_if out_ch();

    assign in_ch.valid       = drv_valid;
    assign in_ch.data_byte   = drv_data;
    assign in_ch.has_byte    = drv_has;
    assign in_ch.message_end = drv_fin;
    assign out_ch.ready      = drv_ready;

    base64_line_wrapping_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (drv_cfg_we),
        .cfg_index (drv_cfg_index),
        .cfg_data  (drv_cfg_data)
    );

    // Encoder model state and its copy of the configuration.
    logic [9:0] lim;
    logic [7:0] brk1;
    logic [7:0] brk2;
    logic       brk_two;
    logic [7:0] pend_hi;
    logic [7:0] pend_lo;
    logic [1:0] group_pos;
    logic [9:0] line_cnt;
    logic [7:0] step_chars [8];
    int         step_count;
    string      b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    msg_item_t pending_items [$];
    enc_char_t expected_chars [$];

    // Bookkeeping shared between the processes; each has a single writer.
    int       items_queued    = 0;
    int       items_accepted  = 0;
    int       chars_checked   = 0;
    int       messages_closed = 0;
    int       mismatches      = 0;
    int       idle_cycles     = 0;
    int       settings_used   = 0;
    bit       byte_taken      = 1'b0;
    bit       char_taken      = 1'b0;
    bit       gaps_on         = 1'b0;
    rx_mode_e rx_mode         = RX_ALWAYS;
    bit       hold_request    = 1'b0;
    bit       hold_served     = 1'b0;
    int       hold_left       = 0;
    int       burst_left      = 1;
    int       gap_left        = 0;
    int       pattern_cnt     = 0;

    // Clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return b64_alphabet[v];
    endfunction

    function automatic void emit_char(input logic [7:0] c);
        if (step_count < 8)
        begin
            step_chars[step_count] = c;
            step_count++;
        end
    endfunction

    function automatic void emit_line_break();
        emit_char(brk1);
        if (brk_two)
            emit_char(brk2);
    endfunction

    // Work out the characters one accepted message item causes and queue them.
    function automatic void encode_item(input logic [7:0] data, input logic has,
                                        input logic fin);
        logic [9:0] thr;
        enc_char_t  ec;
        step_count = 0;
        thr = (lim >= 10'd3) ? lim - 10'd3 : 10'd0;
        if (has)
        begin
            case (group_pos)
                GP_EMPTY:
                begin
                    pend_hi   = data;
                    pend_lo   = 8'h00;
                    group_pos = GP_ONE;
                end
                GP_ONE:
                begin
                    pend_lo   = data;
                    group_pos = GP_TWO;
                end
                default:
                begin
                    emit_char(sextet_char(pend_hi[7:2]));
                    emit_char(sextet_char({pend_hi[1:0], pend_lo[7:4]}));
                    emit_char(sextet_char({pend_lo[3:0], data[7:6]}));
                    emit_char(sextet_char(data[5:0]));
                    line_cnt = line_cnt + 10'd4;
                    if (line_cnt >= thr)
                    begin
                        emit_line_break();
                        line_cnt = 10'd0;
                    end
                    pend_hi   = 8'h00;
                    pend_lo   = 8'h00;
                    group_pos = GP_EMPTY;
                end
            endcase
        end
        // Closing the message flushes held bytes as a padded group and a final break.
        if (fin)
        begin
            if (group_pos == GP_ONE)
            begin
                emit_char(sextet_char(pend_hi[7:2]));
                emit_char(sextet_char({pend_hi[1:0], 4'h0}));
                emit_char(PAD_CHAR);
                emit_char(PAD_CHAR);
            end
            else if (group_pos == GP_TWO)
            begin
                emit_char(sextet_char(pend_hi[7:2]));
                emit_char(sextet_char({pend_hi[1:0], pend_lo[7:4]}));
                emit_char(sextet_char({pend_lo[3:0], 2'b00}));
                emit_char(PAD_CHAR);
            end
            emit_line_break();
            pend_hi   = 8'h00;
            pend_lo   = 8'h00;
            group_pos = GP_EMPTY;
            line_cnt  = 10'd0;
        end
        for (int k = 0; k < step_count; k++)
        begin
            ec.ch       = step_chars[k];
            ec.run_last = (k == step_count - 1);
            ec.done     = (k == step_count - 1) && fin;
            expected_chars.push_back(ec);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at character %0d: %s", chars_checked, msg);
        mismatches++;
    endtask

    // Monitor: checks each character transfer and predicts each byte transfer.
    always @(posedge clk)
    begin
        enc_char_t want;
        if (rst_n)
        begin
            byte_taken = in_ch.valid && in_ch.ready;
            char_taken = out_ch.valid && out_ch.ready;
            if (char_taken)
            begin
                if (expected_chars.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected character %h", out_ch.out_char));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (out_ch.out_char !== want.ch)
                        report_mismatch($sformatf("out_char %h, expected %h",
                                                  out_ch.out_char, want.ch));
                    if (out_ch.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, expected %b",
                                                  out_ch.run_last, want.run_last));
                    if (out_ch.message_done !== want.done)
                        report_mismatch($sformatf("message_done %b, expected %b",
                                                  out_ch.message_done, want.done));
                    if (want.done)
                        messages_closed++;
                end
                chars_checked++;
            end
            if (byte_taken)
            begin
                encode_item(in_ch.data_byte, in_ch.has_byte, in_ch.message_end);
                items_accepted++;
            end
            // Watchdog on cycles with no transfer at all.
            if (byte_taken || char_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Driver: offers queued items in bursts, separated by random gaps when gaps_on is set.
    always @(negedge clk)
    begin
        msg_item_t nxt;
        bit        give;
        if (rst_n && (!drv_valid || byte_taken))
        begin
            give = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain && expected_chars.size() > 0))
            begin
                nxt  = pending_items.pop_front();
                give = 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = gaps_on ? $urandom_range(1, 6) : 0;
                end
            end
            drv_valid <= give;
            if (give)
            begin
                drv_data <= nxt.data;
                drv_has  <= nxt.has;
                drv_fin  <= nxt.fin;
            end
        end
    end

    // Receiver: backpressure by mode, plus one long hold when requested.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_request && !hold_served)
            begin
                hold_left   = HOLD_CYCLES;
                hold_served = 1'b1;
            end
            pattern_cnt = (pattern_cnt + 1) % 7;
            if (hold_left > 0)
            begin
                hold_left--;
                drv_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_RANDOM:  drv_ready <= ($urandom_range(0, 9) >= 3);
                    RX_PATTERN: drv_ready <= (pattern_cnt >= 2);
                    default:    drv_ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic add_item(input logic [7:0] data, input logic has, input logic fin,
                            input bit drain);
        msg_item_t it;
        it.data  = data;
        it.has   = has;
        it.fin   = fin;
        it.drain = drain;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Messages of random length and content, with idle items mixed in and a
    // few messages that run on into the next one.
    task automatic queue_random_messages(input int target, input int max_len,
                                         input bit allow_drain);
        int added;
        int len;
        bit end_on_byte;
        bit skip_end;
        bit drain;
        added = 0;
        while (added < target)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, max_len)
                                              : $urandom_range(0, 10);
            end_on_byte = 1'($urandom_range(0, 1));
            skip_end    = ($urandom_range(0, 9) == 0);
            drain       = allow_drain && ($urandom_range(0, 5) == 0);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
                add_item(8'($urandom_range(0, 255)), 1'b1,
                         end_on_byte && !skip_end && (i == len - 1), drain && (i == 0));
                added++;
            end
            if (!skip_end && (!end_on_byte || len == 0))
            begin
                add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, drain && (len == 0));
                added++;
            end
        end
        // Close whatever is still open so the phase ends idle.
        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
    endtask

    // Wait until every item is taken and every character has come out.
    task automatic wait_drained();
        while (items_accepted != items_queued || expected_chars.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TIME) @(negedge clk);
    endtask

    // Write all four registers on consecutive cycles and track them.
    task automatic set_config(input logic [9:0] limit, input logic [7:0] b1,
                              input logic [7:0] b2, input logic two);
        @(negedge clk);
        drv_cfg_we    <= 1'b1;
        drv_cfg_index <= CFG_LINE_LIMIT;
        drv_cfg_data  <= limit;
        @(negedge clk);
        drv_cfg_index <= CFG_BREAK_FIRST;
        drv_cfg_data  <= {2'b00, b1};
        @(negedge clk);
        drv_cfg_index <= CFG_BREAK_SECOND;
        drv_cfg_data  <= {2'b00, b2};
        @(negedge clk);
        drv_cfg_index <= CFG_BREAK_IS_TWO;
        drv_cfg_data  <= {9'd0, two};
        @(negedge clk);
        drv_cfg_we    <= 1'b0;
        lim     = limit;
        brk1    = b1;
        brk2    = b2;
        brk_two = two;
        settings_used++;
        @(posedge clk);
    endtask

    // Stimulus sequence.
    initial
    begin
        lim       = LINE_LIMIT_RST;
        brk1      = BREAK_FIRST_RST;
        brk2      = BREAK_SECOND_RST;
        brk_two   = 1'b1;
        pend_hi   = 8'h00;
        pend_lo   = 8'h00;
        group_pos = GP_EMPTY;
        line_cnt  = 10'd0;
        settings_used = 1;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults, no gaps: idle item, empty message, padding forms.
        add_item(8'hA5, 1'b0, 1'b0, 1'b0);
        add_item(8'h5A, 1'b0, 1'b1, 1'b0);
        add_item(8'h00, 1'b1, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0, 1'b0);
        add_item(8'hFF, 1'b1, 1'b1, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b1, 1'b0);
        add_item(8'h4D, 1'b1, 1'b0, 1'b0);
        add_item(8'h61, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b0, 1'b0);
        add_item(8'h6E, 1'b1, 1'b1, 1'b0);
        add_item(8'h80, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1, 1'b0);
        wait_drained();

        // Smallest limit: a break after every group; a full group carrying
        // the end gives the most characters, and a bare end right after a
        // wrap still adds its own break.
        set_config(10'd4, 8'h00, 8'hFF, 1'b1);
        gaps_on = 1'b1;
        rx_mode = RX_RANDOM;
        add_item(8'h12, 1'b1, 1'b0, 1'b0);
        add_item(8'h34, 1'b1, 1'b0, 1'b0);
        add_item(8'h56, 1'b1, 1'b1, 1'b0);
        add_item(8'hC3, 1'b1, 1'b0, 1'b0);
        add_item(8'h3C, 1'b1, 1'b0, 1'b0);
        add_item(8'h99, 1'b1, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1, 1'b0);
        queue_random_messages(10, 20, 1'b0);
        wait_drained();

        // Largest limit, zero as the second break character.
        set_config(10'd1023, 8'hFF, 8'h00, 1'b1);
        rx_mode = RX_PATTERN;
        queue_random_messages(10, 24, 1'b1);
        wait_drained();

        // One-character break; the receiver holds off so the input stalls.
        set_config(10'd7, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
        gaps_on      = 1'b0;
        rx_mode      = RX_ALWAYS;
        hold_request = 1'b1;
        queue_random_messages(10, 16, 1'b0);
        wait_drained();

        // Random short limit and break sequence.
        set_config(10'($urandom_range(8, 40)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        gaps_on = 1'b1;
        rx_mode = RX_RANDOM;
        queue_random_messages(10, 30, 1'b1);
        wait_drained();

        // Back to the defaults with a message long enough to wrap.
        set_config(LINE_LIMIT_RST, BREAK_FIRST_RST, BREAK_SECOND_RST, 1'b1);
        rx_mode = RX_PATTERN;
        for (int i = 0; i < 61; i++)
            add_item(8'($urandom_range(0, 255)), 1'b1, i == 60, i == 0);
        queue_random_messages(10, 12, 1'b1);
        wait_drained();

        $display("Covered %0d input transfers over %0d register settings (limits 4 to 1023,",
                 items_accepted, settings_used);
        $display("one- and two-character breaks); checked %0d characters in %0d messages.",
                 chars_checked, messages_closed);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
